FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant that holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) \
    else $error("invariant violated");

// consequence that must hold in the same cycle as its antecedent
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

FILE: design/ors_pkg.sv
// ---------------------------------------------------------------------------
// ors_pkg
// Types and codes shared by the search ROM decision engine.
// ---------------------------------------------------------------------------
package ors_pkg;

  localparam int PosW = 7;

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_BEGIN   = 2'd1,
    ACT_PAIR    = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_BIT      = 3'd0,
    ST_MORE     = 3'd1,
    ST_LAST     = 3'd2,
    ST_NODEV    = 3'd3,
    ST_ERROR    = 3'd4,
    ST_ACK      = 3'd5,
    ST_FINISHED = 3'd6
  } status_t;

  typedef struct packed {
    action_t action;
    logic    presence;
    logic    id_bit;
    logic    complement_bit;
  } item_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [PosW-1:0] last_disc;
    logic [PosW-1:0] last_zero;
    logic            finished;
    logic            active;
  } ctl_t;

endpackage

FILE: design/onewire_rom_search_engine_core.sv
// Throughput: one word per cycle; input register and result register
// form a two-stage pipeline that advances whenever the result is free.
// Reset: synchronous rst clears the search state (id, positions, flags)
// and empties both pipeline stages.
// ---------------------------------------------------------------------------
// onewire_rom_search_engine_core
// Search ROM decision engine: picks write directions and assembles ids.
// ---------------------------------------------------------------------------
module onewire_rom_search_engine_core #(
  parameter int ROM_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic        presence,
  input  logic        id_bit,
  input  logic        complement_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_bit,
  output logic [2:0]  status,
  output logic [63:0] rom_id,
  output logic [6:0]  bit_index
);
  import ors_pkg::*;

  `include "assert_macros.svh"

  localparam logic [PosW-1:0] RomLen = PosW'(ROM_BITS);

  logic                advance;
  logic                item_valid;
  item_t               item;
  ctl_t                ctl;
  ctl_t                ctl_next;
  logic [ROM_BITS-1:0] id;
  logic [ROM_BITS-1:0] id_next;
  logic                wbit_next;
  status_t             status_next;
  logic [ROM_BITS-1:0] rom_next;

  assign advance = !out_valid || !out_stall;

  ors_in_stage u_in (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .presence       (presence),
    .id_bit         (id_bit),
    .complement_bit (complement_bit),
    .advance        (advance),
    .item_valid     (item_valid),
    .item           (item)
  );

  ors_decide #(.ROM_BITS(ROM_BITS)) u_decide (
    .item      (item),
    .ctl       (ctl),
    .id        (id),
    .ctl_next  (ctl_next),
    .id_next   (id_next),
    .write_bit (wbit_next),
    .status    (status_next),
    .rom_id    (rom_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= '0;
      id        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        ctl <= ctl_next;
        id  <= id_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      write_bit <= wbit_next;
      status    <= status_next;
      rom_id    <= 64'(rom_next);
      bit_index <= ctl_next.pos;
    end
  end

  `ASSERT_IMPLIES(a_active_not_done, clk, rst, ctl.active, !ctl.finished)
  `ASSERT_ALWAYS(a_pos_range, clk, rst, ctl.pos <= RomLen)
  `ASSERT_IMPLIES(a_fork_behind_pos, clk, rst, ctl.active, ctl.last_zero <= ctl.pos)
  `ASSERT_IMPLIES(a_pass_end_full, clk, rst,
                  out_valid && (status == ST_LAST || status == ST_MORE),
                  bit_index == RomLen)

endmodule

FILE: design/ors_in_stage.sv
// ---------------------------------------------------------------------------
// ors_in_stage
// Input register: holds one word until the decision stage advances.
// ---------------------------------------------------------------------------
module ors_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    action,
  input  logic          presence,
  input  logic          id_bit,
  input  logic          complement_bit,
  input  logic          advance,
  output logic          item_valid,
  output ors_pkg::item_t item
);
  import ors_pkg::*;

  logic load;

  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.action         <= action_t'(action);
      item.presence       <= presence;
      item.id_bit         <= id_bit;
      item.complement_bit <= complement_bit;
    end
  end

endmodule

FILE: design/ors_decide.sv
// ---------------------------------------------------------------------------
// ors_decide
// Per-word decision: direction choice, id update and pass bookkeeping.
// ---------------------------------------------------------------------------
module ors_decide #(
  parameter int ROM_BITS = 64
) (
  input  ors_pkg::item_t      item,
  input  ors_pkg::ctl_t       ctl,
  input  logic [ROM_BITS-1:0] id,
  output ors_pkg::ctl_t       ctl_next,
  output logic [ROM_BITS-1:0] id_next,
  output logic                write_bit,
  output ors_pkg::status_t    status,
  output logic [ROM_BITS-1:0] rom_id
);
  import ors_pkg::*;

  localparam int IdxW = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
  localparam logic [PosW-1:0] RomLen = PosW'(ROM_BITS);

  logic [PosW-1:0] n;
  logic [IdxW-1:0] idx;
  logic            dir;

  assign n   = ctl.pos + PosW'(1);
  assign idx = ctl.pos[IdxW-1:0];

  always_comb begin
    ctl_next  = ctl;
    id_next   = id;
    write_bit = 1'b0;
    status    = ST_ERROR;
    dir       = 1'b0;
    unique case (item.action)
      ACT_RESTART: begin
        ctl_next = '0;
        id_next  = '0;
        status   = ST_ACK;
      end
      ACT_BEGIN: begin
        if (ctl.finished) begin
          status = ST_FINISHED;
        end else if (!item.presence) begin
          ctl_next.finished = 1'b1;
          ctl_next.active   = 1'b0;
          ctl_next.pos      = '0;
          status            = ST_NODEV;
        end else begin
          ctl_next.active    = 1'b1;
          ctl_next.pos       = '0;
          ctl_next.last_zero = '0;
          status             = ST_ACK;
        end
      end
      ACT_PAIR: begin
        if (ctl.active && (ctl.pos < RomLen)) begin
          if (item.id_bit && item.complement_bit) begin
            ctl_next.active   = 1'b0;
            ctl_next.finished = 1'b1;
            status            = ST_ERROR;
          end else begin
            if (item.id_bit != item.complement_bit) begin
              dir = item.id_bit;
            end else begin
              if (n < ctl.last_disc) begin
                dir = id[idx];
              end else begin
                dir = (n == ctl.last_disc);
              end
              if (!dir) begin
                ctl_next.last_zero = n;
              end
            end
            id_next[idx] = dir;
            ctl_next.pos = n;
            write_bit    = dir;
            status       = ST_BIT;
            if (n >= RomLen) begin
              ctl_next.active    = 1'b0;
              ctl_next.last_disc = ctl_next.last_zero;
              if (ctl_next.last_zero == '0) begin
                ctl_next.finished = 1'b1;
                status            = ST_LAST;
              end else begin
                status = ST_MORE;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // keep only the bits decided so far in this pass
  always_comb begin
    for (int i = 0; i < ROM_BITS; i++) begin
      rom_id[i] = id_next[i] && (PosW'(i) < ctl_next.pos);
    end
  end

endmodule

FILE: verif/onewire_rom_search_engine_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// onewire_rom_search_engine_core_tb
// Drives restart, begin-pass and bit-pair words into the search ROM engine
// and checks every result word against a cycle-free model of the
// last-discrepancy search or a directed table of special cases; then emulated
// buses of random device sets are enumerated, with noise words, stray pairs,
// aborted passes and bus errors mixed in. Both sides idle at random.
// ---------------------------------------------------------------------------
module onewire_rom_search_engine_core_tb;
  import ors_pkg::*;

  localparam int ROM_BITS = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WORD_TARGET = 1900;

  typedef struct packed {
    logic            write_bit;
    status_t         status;
    logic [63:0]     rom_id;
    logic [PosW-1:0] bit_index;
  } result_t;

  typedef struct packed {
    logic [63:0]     id;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] last_disc;
    logic [PosW-1:0] last_zero;
    logic            finished;
    logic            active;
  } engine_t;

  typedef struct packed {
    logic [1:0] act;
    logic       pres;
    logic       idb;
    logic       cmp;
    logic       fixed;
    result_t    exp;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = 2'd0;
  logic        presence = 1'b0;
  logic        id_bit = 1'b0;
  logic        complement_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_bit;
  logic [2:0]  status;
  logic [63:0] rom_id;
  logic [6:0]  bit_index;

  engine_t eng = '0;
  result_t expected_words[$];
  int      failures = 0;
  int      words_sent = 0;
  int      burst_left = 0;
  bit      hold_req = 1'b0;

  onewire_rom_search_engine_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .presence(presence),
    .id_bit(id_bit),
    .complement_bit(complement_bit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .write_bit(write_bit),
    .status(status),
    .rom_id(rom_id),
    .bit_index(bit_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic result_t search_step(input logic [1:0] act, input logic pres,
                                          input logic idb, input logic cmp);
    result_t         r;
    logic [PosW-1:0] n;
    logic            dir;
    r = '0;
    r.status = ST_ERROR;
    case (act)
      ACT_RESTART: begin
        eng = '0;
        r.status = ST_ACK;
      end
      ACT_BEGIN: begin
        if (eng.finished) begin
          r.status = ST_FINISHED;
        end else if (!pres) begin
          eng.finished = 1'b1;
          eng.active = 1'b0;
          eng.pos = '0;
          r.status = ST_NODEV;
        end else begin
          eng.active = 1'b1;
          eng.pos = '0;
          eng.last_zero = '0;
          r.status = ST_ACK;
        end
      end
      ACT_PAIR: begin
        if (eng.active && eng.pos < ROM_BITS) begin
          if (idb && cmp) begin
            eng.active = 1'b0;
            eng.finished = 1'b1;
          end else begin
            n = eng.pos + 7'd1;
            if (idb != cmp) begin
              dir = idb;
            end else begin
              if (n < eng.last_disc) dir = eng.id[eng.pos[5:0]];
              else dir = (n == eng.last_disc);
              if (!dir) eng.last_zero = n;
            end
            eng.id[eng.pos[5:0]] = dir;
            eng.pos = n;
            r.write_bit = dir;
            r.status = ST_BIT;
            if (eng.pos >= ROM_BITS) begin
              eng.active = 1'b0;
              eng.last_disc = eng.last_zero;
              if (eng.last_disc == '0) begin
                eng.finished = 1'b1;
                r.status = ST_LAST;
              end else begin
                r.status = ST_MORE;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (eng.pos >= ROM_BITS) r.rom_id = eng.id;
    else r.rom_id = eng.id & ((64'd1 << eng.pos) - 64'd1);
    r.bit_index = eng.pos;
    return r;
  endfunction

  function automatic plan_row_t row(input logic [1:0] act, input logic pres, input logic idb,
                                    input logic cmp, input logic fixed, input status_t st,
                                    input logic wb, input logic [63:0] rom,
                                    input logic [6:0] idx);
    plan_row_t p;
    p.act = act;
    p.pres = pres;
    p.idb = idb;
    p.cmp = cmp;
    p.fixed = fixed;
    p.exp.write_bit = wb;
    p.exp.status = st;
    p.exp.rom_id = rom;
    p.exp.bit_index = idx;
    return p;
  endfunction

  task automatic send_word(input logic [1:0] act, input logic pres, input logic idb,
                           input logic cmp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    presence <= pres;
    id_bit <= idb;
    complement_bit <= cmp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_checked(input logic [1:0] act, input logic pres, input logic idb,
                              input logic cmp, output result_t r);
    send_word(act, pres, idb, cmp);
    r = search_step(act, pres, idb, cmp);
    expected_words.push_back(r);
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // emulate a wired-AND bus of n_dev devices through a full enumeration, unless aborted
  task automatic run_enumeration(input int n_dev, input bit with_extremes);
    logic [63:0] devs [8];
    logic [63:0] base;
    logic [7:0]  alive;
    logic        idb;
    logic        cmp;
    result_t     r;
    bit          done;
    int          p;
    int          abort_at;
    int          passes;
    base = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 3))
        0: devs[i] = {$urandom, $urandom};
        1: devs[i] = base ^ ({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
        2: devs[i] = base ^ (64'd1 << $urandom_range(0, 63));
        default: devs[i] = $urandom_range(0, 1) ? '1 : '0;
      endcase
    end
    if (with_extremes) begin
      devs[0] = '0;
      devs[1] = '1;
    end
    send_checked(ACT_RESTART, rand_bit(), rand_bit(), rand_bit(), r);
    done = 1'b0;
    passes = 0;
    while (!done) begin
      if ($urandom_range(0, 7) == 0)
        send_checked(ACT_PAIR, rand_bit(), rand_bit(), rand_bit(), r);
      send_checked(ACT_BEGIN, n_dev != 0, rand_bit(), rand_bit(), r);
      if (r.status != ST_ACK) begin
        done = 1'b1;
      end else begin
        alive = (8'd1 << n_dev) - 8'd1;
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : ROM_BITS;
        p = 0;
        while (p < ROM_BITS && !done) begin
          if (p == abort_at) begin
            abort_at = ROM_BITS;
            if ($urandom_range(0, 1)) begin
              send_checked(ACT_BEGIN, 1'b1, rand_bit(), rand_bit(), r);
              alive = (8'd1 << n_dev) - 8'd1;
              p = 0;
            end else begin
              send_checked(ACT_PAIR, rand_bit(), 1'b1, 1'b1, r);
              done = 1'b1;
            end
          end else begin
            idb = 1'b1;
            cmp = 1'b1;
            for (int i = 0; i < n_dev; i++) begin
              if (alive[i]) begin
                if (devs[i][p]) cmp = 1'b0;
                else idb = 1'b0;
              end
            end
            send_checked(ACT_PAIR, rand_bit(), idb, cmp, r);
            for (int i = 0; i < n_dev; i++)
              if (devs[i][p] != r.write_bit) alive[i] = 1'b0;
            p++;
          end
        end
        if (!done && r.status != ST_MORE) done = 1'b1;
        passes++;
        if (passes > n_dev + 4) done = 1'b1;
      end
    end
  endtask

  initial begin : receiver
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((left % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t exp;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word: wb %0b st %0d id %h idx %0d",
                   write_bit, status, rom_id, bit_index);
      end else begin
        exp = expected_words.pop_front();
        if (write_bit !== exp.write_bit || status !== exp.status ||
            rom_id !== exp.rom_id || bit_index !== exp.bit_index) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected wb %0b st %0d id %h idx %0d,",
                     exp.write_bit, exp.status, exp.rom_id, exp.bit_index,
                     " got wb %0b st %0d id %h idx %0d",
                     write_bit, status, rom_id, bit_index);
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [19];
    result_t   r;
    int        enum_no;
    int        n_dev;
    int        k;
    int        guard;
    plan[0]  = row(ACT_PAIR,    1'b0, 1'b1, 1'b0, 1'b1, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[1]  = row(ACT_UNUSED,  1'b1, 1'b1, 1'b1, 1'b1, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[2]  = row(ACT_BEGIN,   1'b0, 1'b0, 1'b0, 1'b1, ST_NODEV,    1'b0, 64'd0, 7'd0);
    plan[3]  = row(ACT_BEGIN,   1'b1, 1'b0, 1'b0, 1'b1, ST_FINISHED, 1'b0, 64'd0, 7'd0);
    plan[4]  = row(ACT_PAIR,    1'b0, 1'b0, 1'b1, 1'b1, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[5]  = row(ACT_RESTART, 1'b0, 1'b0, 1'b0, 1'b1, ST_ACK,      1'b0, 64'd0, 7'd0);
    plan[6]  = row(ACT_BEGIN,   1'b1, 1'b1, 1'b1, 1'b1, ST_ACK,      1'b0, 64'd0, 7'd0);
    plan[7]  = row(ACT_PAIR,    1'b0, 1'b1, 1'b0, 1'b1, ST_BIT,      1'b1, 64'd1, 7'd1);
    plan[8]  = row(ACT_PAIR,    1'b1, 1'b0, 1'b1, 1'b1, ST_BIT,      1'b0, 64'd1, 7'd2);
    plan[9]  = row(ACT_PAIR,    1'b0, 1'b0, 1'b0, 1'b0, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[10] = row(ACT_BEGIN,   1'b1, 1'b0, 1'b0, 1'b1, ST_ACK,      1'b0, 64'd0, 7'd0);
    plan[11] = row(ACT_PAIR,    1'b1, 1'b0, 1'b0, 1'b0, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[12] = row(ACT_PAIR,    1'b0, 1'b1, 1'b1, 1'b0, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[13] = row(ACT_BEGIN,   1'b1, 1'b1, 1'b0, 1'b0, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[14] = row(ACT_UNUSED,  1'b0, 1'b0, 1'b0, 1'b0, ST_ERROR,    1'b0, 64'd0, 7'd0);
    plan[15] = row(ACT_RESTART, 1'b1, 1'b1, 1'b1, 1'b1, ST_ACK,      1'b0, 64'd0, 7'd0);
    plan[16] = row(ACT_BEGIN,   1'b0, 1'b1, 1'b0, 1'b1, ST_NODEV,    1'b0, 64'd0, 7'd0);
    plan[17] = row(ACT_RESTART, 1'b0, 1'b0, 1'b1, 1'b1, ST_ACK,      1'b0, 64'd0, 7'd0);
    plan[18] = row(ACT_PAIR,    1'b1, 1'b1, 1'b1, 1'b1, ST_ERROR,    1'b0, 64'd0, 7'd0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      send_word(plan[i].act, plan[i].pres, plan[i].idb, plan[i].cmp);
      r = search_step(plan[i].act, plan[i].pres, plan[i].idb, plan[i].cmp);
      expected_words.push_back(plan[i].fixed ? plan[i].exp : r);
    end
    enum_no = 0;
    while (words_sent < WORD_TARGET) begin
      if (enum_no == 1) hold_req = 1'b1;
      if (enum_no < 2) n_dev = 3;
      else n_dev = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
      run_enumeration(n_dev, enum_no == 0);
      k = $urandom_range(0, 4);
      repeat (k)
        send_checked(2'($urandom_range(0, 3)), rand_bit(), rand_bit(), rand_bit(), r);
      if (enum_no == 0 || $urandom_range(0, 2) == 0) begin
        sender_idle();
        while (expected_words.size() != 0) @(posedge clk);
      end
      enum_no++;
    end
    sender_idle();
    guard = 0;
    while (expected_words.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (expected_words.size() != 0) begin
      failures++;
      if (failures <= 10)
        $display("%0d expected result words never arrived", expected_words.size());
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
